/* hw/rtl/crl_pkg.sv */
// types and codes shared by the cursor ring list design
package crl_pkg;

   // operation codes carried in the request tuser
   typedef enum logic [2:0] {
      OP_INSERT = 3'd0,
      OP_REMOVE = 3'd1,
      OP_NEXT   = 3'd2,
      OP_PREV   = 3'd3,
      OP_WALK   = 3'd4
   } kind_type;

   // result status carried in the response tuser
   typedef enum logic [1:0] {
      RS_OK    = 2'd0,
      RS_EMPTY = 2'd1,
      RS_FULL  = 2'd2
   } status_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_INS_LINK,
      ST_INS_FIX,
      ST_REM_LINK,
      ST_STEP_LINK,
      ST_EMIT,
      ST_WALK
   } state_type;

   localparam int DATA_OUT_BITS = 32;
   localparam int VALUE_IN_BITS = 32;
   localparam int COUNT_OUT_BITS = 6;

endpackage

/* hw/rtl/cursor_ring_list_top.sv */
// cursor ring list: circular doubly linked list with a cursor over a node pool
//
//   channel  dir  tdata                               tuser          tlast
//   req_     in   [31:0] value                        [2:0] kind     -
//   rsp_     out  [31:0] data_out, [37:32] count      [1:0] status   last
//
// insert: free-slot scan over the used slots below the lowest free one, link, fix-up, emit;
//   the fix-up step is skipped on an empty ring
// remove, step next, step prev: link step, then emit; error results go straight to emit
// walk: one read per element, in ring order, set by the single read port of each link memory
// reset clears the slot-used flags, cursor and count at once; no clearing pass
// a stalled response holds the sequencer only when it has a new result to load
module cursor_ring_list_top
   import crl_pkg::*;
#(
   parameter int CAPACITY   = 32,
   parameter int VALUE_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic [2:0]  req_tuser,   // [2:0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] data_out, [37:32] count, [39:38] zero
   output logic [1:0]  rsp_tuser,   // [1:0] status
   output logic        rsp_tlast
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);

   // sequencer and ring state
   state_type               state_ff, state_in;
   kind_type                op_ff, op_in;
   status_type              status_ff, status_in;
   logic [VALUE_BITS-1:0]   ins_val_ff, ins_val_in;
   logic [IDX_W-1:0]        cursor_ff, cursor_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;       // shared scan index / walk counter
   logic [IDX_W-1:0]        new_slot_ff, new_slot_in;
   logic [CAPACITY-1:0]     used_ff, used_in;

   // node pool memories
   logic [VALUE_BITS-1:0]   value_mem [CAPACITY];
   logic [IDX_W-1:0]        next_mem  [CAPACITY];
   logic [IDX_W-1:0]        prev_mem  [CAPACITY];
   logic [VALUE_BITS-1:0]   val_q;
   logic [IDX_W-1:0]        next_q, prev_q;

   logic                    rd_en;
   logic [IDX_W-1:0]        rd_addr;
   logic                    vm_we, nx_we, pv_we;
   logic [IDX_W-1:0]        vm_wa, nx_wa, pv_wa;
   logic [IDX_W-1:0]        nx_wd, pv_wd;

   // response register
   logic                      rsp_valid_ff;
   logic [DATA_OUT_BITS-1:0]  rsp_data_ff;
   status_type                rsp_status_ff;
   logic [COUNT_OUT_BITS-1:0] rsp_count_ff;
   logic                      rsp_last_ff;

   logic                      out_load;
   logic                      out_free;
   logic [DATA_OUT_BITS-1:0]  out_data;
   logic                      out_last;

   logic                      req_fire;
   kind_type                  req_kind;
   logic signed [VALUE_IN_BITS-1:0] req_val_s;
   logic signed [63:0]        req_val_x;
   logic                      ring_full;
   logic                      ring_empty;
   logic                      walk_last;
   logic                      scan_free;
   logic [IDX_W-1:0]          step_slot;

   // sign-extend a stored value to the output width
   function automatic logic [DATA_OUT_BITS-1:0] val_out(input logic [VALUE_BITS-1:0] v);
      logic signed [VALUE_BITS-1:0] s;
      logic signed [63:0]           w;
      s = signed'(v);
      w = 64'(s);
      return w[DATA_OUT_BITS-1:0];
   endfunction

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign req_kind   = kind_type'(req_tuser);
   assign req_val_s  = signed'(req_tdata);
   assign req_val_x  = 64'(req_val_s);
   assign ring_full  = (count_ff == CNT_W'(CAPACITY));
   assign ring_empty = (count_ff == '0);
   assign walk_last  = ((cnt_ff + CNT_W'(1)) == count_ff);
   assign scan_free  = !used_ff[cnt_ff[IDX_W-1:0]];
   assign step_slot  = (op_ff == OP_NEXT) ? next_q : prev_q;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_kind) inside
                  OP_INSERT: state_in = ring_full ? ST_EMIT : ST_SCAN;
                  OP_REMOVE: state_in = ring_empty ? ST_EMIT : ST_REM_LINK;
                  OP_NEXT, OP_PREV: state_in = ring_empty ? ST_EMIT : ST_STEP_LINK;
                  OP_WALK:   state_in = ring_empty ? ST_EMIT : ST_WALK;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_SCAN:      if (scan_free) state_in = ST_INS_LINK;
         ST_INS_LINK:  state_in = ring_empty ? ST_EMIT : ST_INS_FIX;
         ST_INS_FIX:   state_in = ST_EMIT;
         ST_REM_LINK:  state_in = ST_EMIT;
         ST_STEP_LINK: state_in = ST_EMIT;
         ST_EMIT:      if (out_free) state_in = ST_IDLE;
         ST_WALK:      if (out_free && walk_last) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // datapath controls
   always_comb begin
      op_in       = op_ff;
      status_in   = status_ff;
      ins_val_in  = ins_val_ff;
      cursor_in   = cursor_ff;
      count_in    = count_ff;
      cnt_in      = cnt_ff;
      new_slot_in = new_slot_ff;
      used_in     = used_ff;
      rd_en       = 1'b0;
      rd_addr     = cursor_ff;
      vm_we       = 1'b0;
      vm_wa       = new_slot_ff;
      nx_we       = 1'b0;
      nx_wa       = new_slot_ff;
      nx_wd       = new_slot_ff;
      pv_we       = 1'b0;
      pv_wa       = new_slot_ff;
      pv_wd       = new_slot_ff;
      out_load    = 1'b0;
      out_data    = '0;
      out_last    = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               // fetch the cursor node for every operation
               op_in      = req_kind;
               ins_val_in = req_val_x[VALUE_BITS-1:0];
               rd_en      = 1'b1;
               cnt_in     = '0;
               status_in  = RS_OK;
               if (req_kind == OP_INSERT) begin
                  if (ring_full) status_in = RS_FULL;
               end else if (ring_empty) begin
                  status_in = RS_EMPTY;
               end
            end
         end
         ST_SCAN: begin
            if (scan_free) begin
               new_slot_in = cnt_ff[IDX_W-1:0];
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_INS_LINK: begin
            vm_we = 1'b1;
            nx_we = 1'b1;
            pv_we = 1'b1;
            if (!ring_empty) begin
               nx_wd = next_q;
               pv_wd = cursor_ff;
            end
            used_in[new_slot_ff] = 1'b1;
            count_in = count_ff + CNT_W'(1);
            if (ring_empty) cursor_in = new_slot_ff;
         end
         ST_INS_FIX: begin
            // old successor points back, cursor node points forward
            pv_we     = 1'b1;
            pv_wa     = next_q;
            nx_we     = 1'b1;
            nx_wa     = cursor_ff;
            cursor_in = new_slot_ff;
         end
         ST_REM_LINK: begin
            used_in[cursor_ff] = 1'b0;
            count_in = count_ff - CNT_W'(1);
            if (count_ff == CNT_W'(1)) begin
               cursor_in = '0;
            end else begin
               nx_we     = 1'b1;
               nx_wa     = prev_q;
               nx_wd     = next_q;
               pv_we     = 1'b1;
               pv_wa     = next_q;
               pv_wd     = prev_q;
               cursor_in = next_q;
            end
         end
         ST_STEP_LINK: begin
            cursor_in = step_slot;
            rd_en     = 1'b1;
            rd_addr   = step_slot;
         end
         ST_EMIT: begin
            out_load = 1'b1;
            if (status_ff != RS_OK) begin
               out_data = '0;
            end else if (op_ff == OP_INSERT) begin
               out_data = val_out(ins_val_ff);
            end else begin
               out_data = val_out(val_q);
            end
         end
         ST_WALK: begin
            out_load = 1'b1;
            out_data = val_out(val_q);
            out_last = walk_last;
            if (out_free && !walk_last) begin
               cnt_in  = cnt_ff + CNT_W'(1);
               rd_en   = 1'b1;
               rd_addr = next_q;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cursor_ff <= '0;
         count_ff  <= '0;
         used_ff   <= '0;
         cnt_ff    <= '0;
         op_ff     <= OP_INSERT;
         status_ff <= RS_OK;
      end else begin
         state_ff  <= state_in;
         cursor_ff <= cursor_in;
         count_ff  <= count_in;
         used_ff   <= used_in;
         cnt_ff    <= cnt_in;
         op_ff     <= op_in;
         status_ff <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      ins_val_ff  <= ins_val_in;
      new_slot_ff <= new_slot_in;
   end

   // node pool: one write and one registered read per memory each cycle
   always_ff @(posedge clock) begin
      if (vm_we) value_mem[vm_wa] <= ins_val_ff;
      if (rd_en) val_q <= value_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (nx_we) next_mem[nx_wa] <= nx_wd;
      if (rd_en) next_q <= next_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (pv_we) prev_mem[pv_wa] <= pv_wd;
      if (rd_en) prev_q <= prev_mem[rd_addr];
   end

   // response register, refilled in the cycle it drains
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load && out_free) begin
         rsp_data_ff   <= out_data;
         rsp_status_ff <= status_ff;
         rsp_count_ff  <= COUNT_OUT_BITS'(count_ff);
         rsp_last_ff   <= out_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_count_ff, rsp_data_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   // element count always matches the number of slots in use
   a_count_matches_used: assert property (@(posedge clock) disable iff (reset)
      $countones(used_ff) == 32'(count_ff))
      else $error("count does not match slot-used map");

   // ring never holds more than the pool
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("count above capacity");

   // walk never runs past the element count
   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (cnt_ff < count_ff))
      else $error("walk beyond ring length");

   // insert on a full ring leaves the count alone
   a_full_insert_holds: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_kind == OP_INSERT && ring_full) |=> ring_full)
      else $error("full insert changed the ring");
`endif

endmodule
